>>> design/ckt_pkg.sv
// Shared types and constants for the card key table.
package ckt_pkg;

  localparam int unsigned WORD_W    = 32;
  localparam int unsigned IN_WORDS  = 3;
  localparam int unsigned CNT_OUT_W = 7;

  typedef enum logic [1:0] {
    CMD_LOOKUP = 2'd0,
    CMD_SAVE   = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_COUNT  = 2'd3
  } ckt_cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } ckt_state_e;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } ckt_mem_ctl_t;

endpackage

>>> design/ckt_store.sv
// Key storage: one write port, one read port with registered read data.
module ckt_store
  import ckt_pkg::*;
#(
  parameter int unsigned MAX_KEYS = 64,
  parameter int unsigned KEY_W    = 96,
  parameter int unsigned AW       = 6
) (
  input  logic               clk_i,
  input  ckt_mem_ctl_t       mem_ctl_i,
  input  logic [AW-1:0]      raddr_i,
  input  logic [AW-1:0]      waddr_i,
  input  logic [KEY_W-1:0]   wdata_i,
  output logic [KEY_W-1:0]   rdata_o
);

  logic [KEY_W-1:0] mem_q [MAX_KEYS];
  logic [KEY_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (mem_ctl_i.wr_en) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (mem_ctl_i.rd_en) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/ckt_seq.sv
// Command sequencer: scans stored entries through the shared comparator, appends, clears, reports.
module ckt_seq
  import ckt_pkg::*;
#(
  parameter int unsigned MAX_KEYS = 64,
  parameter int unsigned KEY_W    = 96,
  parameter int unsigned AW       = 6,
  parameter int unsigned CNT_W    = 7
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  ckt_cmd_e           cmd_i,
  input  logic [KEY_W-1:0]   key_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               matched_o,
  output logic               table_full_o,
  output logic [CNT_W-1:0]   entry_count_o,
  output ckt_mem_ctl_t       mem_ctl_o,
  output logic [AW-1:0]      raddr_o,
  output logic [AW-1:0]      waddr_o,
  output logic [KEY_W-1:0]   wdata_o,
  input  logic [KEY_W-1:0]   rdata_i
);

  ckt_state_e       state_q, state_d;
  ckt_cmd_e         cmd_q, cmd_d;
  logic [KEY_W-1:0] key_q, key_d;
  logic [CNT_W-1:0] idx_q, idx_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             rd_vld_q, rd_vld_d;
  logic             hit_q, hit_d;
  logic             full_q, full_d;
  logic             out_valid_q, out_valid_d;
  logic             out_hit_q, out_hit_d;
  logic             out_full_q, out_full_d;
  logic [CNT_W-1:0] out_cnt_q, out_cnt_d;
  logic             full_now;

  assign full_now = (count_q >= CNT_W'(MAX_KEYS));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rd_vld_q    <= rd_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    key_q      <= key_d;
    idx_q      <= idx_d;
    hit_q      <= hit_d;
    full_q     <= full_d;
    out_hit_q  <= out_hit_d;
    out_full_q <= out_full_d;
    out_cnt_q  <= out_cnt_d;
  end

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    key_d       = key_q;
    idx_d       = idx_q;
    count_d     = count_q;
    rd_vld_d    = 1'b0;
    hit_d       = hit_q;
    full_d      = full_q;
    out_valid_d = out_valid_q;
    out_hit_d   = out_hit_q;
    out_full_d  = out_full_q;
    out_cnt_d   = out_cnt_q;
    mem_ctl_o   = '0;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_d  = cmd_i;
          key_d  = key_i;
          idx_d  = '0;
          hit_d  = 1'b0;
          full_d = 1'b0;
          if (cmd_i == CMD_LOOKUP || cmd_i == CMD_SAVE) begin
            state_d = ST_SCAN;
          end else begin
            if (cmd_i == CMD_CLEAR) begin
              count_d = '0;
            end
            state_d = ST_FINISH;
          end
        end
      end
      ST_SCAN: begin
        // data for the entry read last cycle is compared here
        if (rd_vld_q && rdata_i == key_q) begin
          hit_d = 1'b1;
        end
        if (idx_q != count_q) begin
          mem_ctl_o.rd_en = 1'b1;
          idx_d           = idx_q + CNT_W'(1);
          rd_vld_d        = 1'b1;
        end else if (!rd_vld_q) begin
          state_d = ST_FINISH;
          if (cmd_q == CMD_SAVE) begin
            full_d = full_now;
            if (!hit_q && !full_now) begin
              mem_ctl_o.wr_en = 1'b1;
              count_d         = count_q + CNT_W'(1);
            end
          end
        end
      end
      ST_FINISH: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_hit_d   = hit_q;
          out_full_d  = full_q;
          out_cnt_d   = count_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign in_stall_o    = (state_q != ST_IDLE);
  assign out_valid_o   = out_valid_q;
  assign matched_o     = out_hit_q;
  assign table_full_o  = out_full_q;
  assign entry_count_o = out_cnt_q;
  assign raddr_o       = idx_q[AW-1:0];
  assign waddr_o       = count_q[AW-1:0];
  assign wdata_o       = key_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_KEYS))
    else $error("entry count beyond table size");

  a_write_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_ctl_o.wr_en |-> (!hit_q && !full_now && cmd_q == CMD_SAVE))
    else $error("append of duplicate or into full table");

  a_read_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_ctl_o.rd_en |-> (idx_q < count_q))
    else $error("read of unwritten entry");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q != ST_IDLE))
    else $error("sequencer idle right after accepting an item");

endmodule

>>> design/card_key_table_core.sv
// Card key table top level: key assembly, sequencer and key storage.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) takes one command item with a
//   card key of three 32-bit words. Output channel (out_valid_o /
//   out_stall_i) gives one result item per command: matched, table_full and
//   the entry count after the command.
//   Lookup and save read every stored entry once through the single
//   memory read port and one key comparator, one entry per cycle.
//   The next item is taken in the cycle after the result is loaded into
//   the output register, so one command completes before the next is
//   accepted; lookup and save scan up to MAX_KEYS stored entries.
//   A pending result in the output register does not block acceptance;
//   a stalled receiver only holds the sequencer once the next result is
//   ready and the output register is still full.
//   Reset empties the table (count to zero) and drops any pending result;
//   stored key words keep whatever they held and are never read until
//   written again.
module card_key_table_core
  import ckt_pkg::*;
#(
  parameter int unsigned MAX_KEYS  = 64,
  parameter int unsigned KEY_WORDS = 3
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           command_i,
  input  logic [WORD_W-1:0]    key_word0_i,
  input  logic [WORD_W-1:0]    key_word1_i,
  input  logic [WORD_W-1:0]    key_word2_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 matched_o,
  output logic                 table_full_o,
  output logic [CNT_OUT_W-1:0] entry_count_o
);

  localparam int unsigned KEY_W = KEY_WORDS * WORD_W;
  localparam int unsigned AW    = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_KEYS + 1);

  logic [IN_WORDS*WORD_W-1:0] in_words;
  logic [KEY_W-1:0]           key;
  logic [CNT_W-1:0]           count;
  ckt_mem_ctl_t               mem_ctl;
  logic [AW-1:0]              raddr;
  logic [AW-1:0]              waddr;
  logic [KEY_W-1:0]           wdata;
  logic [KEY_W-1:0]           rdata;

  assign in_words = {key_word2_i, key_word1_i, key_word0_i};

  // words past the three input fields are zero
  for (genvar w = 0; w < KEY_WORDS; w++) begin : g_key
    if (w < IN_WORDS) begin : g_in
      assign key[w*WORD_W +: WORD_W] = in_words[w*WORD_W +: WORD_W];
    end else begin : g_zero
      assign key[w*WORD_W +: WORD_W] = '0;
    end
  end

  ckt_seq #(
    .MAX_KEYS (MAX_KEYS),
    .KEY_W    (KEY_W),
    .AW       (AW),
    .CNT_W    (CNT_W)
  ) u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .cmd_i         (ckt_cmd_e'(command_i)),
    .key_i         (key),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .matched_o     (matched_o),
    .table_full_o  (table_full_o),
    .entry_count_o (count),
    .mem_ctl_o     (mem_ctl),
    .raddr_o       (raddr),
    .waddr_o       (waddr),
    .wdata_o       (wdata),
    .rdata_i       (rdata)
  );

  ckt_store #(
    .MAX_KEYS (MAX_KEYS),
    .KEY_W    (KEY_W),
    .AW       (AW)
  ) u_store (
    .clk_i     (clk_i),
    .mem_ctl_i (mem_ctl),
    .raddr_i   (raddr),
    .waddr_i   (waddr),
    .wdata_i   (wdata),
    .rdata_o   (rdata)
  );

  assign entry_count_o = CNT_OUT_W'(count);

endmodule
